// ===== rtl/core/narp_pkg.sv =====
// ----------------------------------------------------------------------------
// narp_pkg
// Shared types, codes and constants of the note arpeggiator.
// ----------------------------------------------------------------------------
package narp_pkg;

    localparam int MAX_NOTES_DEF = 16;
    localparam int PITCH_W       = 16;
    localparam int KIND_W        = 3;
    localparam int ACT_W         = 3;
    localparam int MODE_W        = 2;
    localparam int LFSR_W        = 16;
    localparam int STEP_CNT_W    = $clog2(LFSR_W);

    localparam logic [LFSR_W-1:0] LFSR_SEED = 16'hACE1;

    // request kinds
    localparam logic [KIND_W-1:0] KIND_NOTE_ON    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_NOTE_OFF   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_ALL_OFF    = 3'd2;
    localparam logic [KIND_W-1:0] KIND_STEP_BEGIN = 3'd3;
    localparam logic [KIND_W-1:0] KIND_STEP_END   = 3'd4;

    // arpeggio modes
    localparam logic [MODE_W-1:0] MODE_NONE   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_UP     = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DOWN   = 2'd2;
    localparam logic [MODE_W-1:0] MODE_RANDOM = 2'd3;

    // result actions
    localparam logic [ACT_W-1:0] ACT_NONE      = 3'd0;
    localparam logic [ACT_W-1:0] ACT_START     = 3'd1;
    localparam logic [ACT_W-1:0] ACT_STOP      = 3'd2;
    localparam logic [ACT_W-1:0] ACT_RUN_START = 3'd3;
    localparam logic [ACT_W-1:0] ACT_RUN_STOP  = 3'd4;
    localparam logic [ACT_W-1:0] ACT_DROPPED   = 3'd5;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_MOD
    } state_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_INSERT,
        OP_REMOVE,
        OP_CLEAR,
        OP_STEP
    } op_t;

    // controller to datapath
    typedef struct packed {
        logic              item_load;
        op_t               op;
        logic              mod_start;
        logic              out_load;
        logic [ACT_W-1:0]  action;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              hit;
        logic              full;
        logic              empty;
        logic              last_one;
        logic              running;
        logic              mode_none;
        logic              mod_busy;
        logic              out_busy;
    } stat_t;

    // fibonacci lfsr, taps 16 14 13 11, shifted right
    function automatic logic [LFSR_W-1:0] lfsr_step(input logic [LFSR_W-1:0] s);
        logic fb;
        fb = s[0] ^ s[2] ^ s[3] ^ s[5];
        return {fb, s[LFSR_W-1:1]};
    endfunction

endpackage

// ===== rtl/core/narp_item_if.sv =====
// ----------------------------------------------------------------------------
// narp_item_if
// Request channel: one note or tick event per transfer.
// ----------------------------------------------------------------------------
interface narp_item_if;
    logic                           valid;
    logic                           ready;
    logic [narp_pkg::KIND_W-1:0]    kind;
    logic [narp_pkg::PITCH_W-1:0]   pitch_code;

    modport source (output valid, output kind, output pitch_code, input ready);
    modport sink   (input valid, input kind, input pitch_code, output ready);
endinterface

// ===== rtl/core/narp_result_if.sv =====
// ----------------------------------------------------------------------------
// narp_result_if
// Result channel: one result per request.
// ----------------------------------------------------------------------------
interface narp_result_if #(
    parameter int MAX_NOTES = narp_pkg::MAX_NOTES_DEF
);
    localparam int CNT_W = $clog2(MAX_NOTES + 1);

    logic                           valid;
    logic                           ready;
    logic [narp_pkg::ACT_W-1:0]     action;
    logic [narp_pkg::PITCH_W-1:0]   note_pitch;
    logic [CNT_W-1:0]               held_count;
    logic                           running;

    modport source (output valid, output action, output note_pitch, output held_count,
                    output running, input ready);
    modport sink   (input valid, input action, input note_pitch, input held_count,
                    input running, output ready);
endinterface

// ===== rtl/core/narp_cfg_if.sv =====
// ----------------------------------------------------------------------------
// narp_cfg_if
// Configuration write channel for the arpeggio mode register.
// ----------------------------------------------------------------------------
interface narp_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [narp_pkg::MODE_W-1:0]    arp_mode;

    modport source (output valid, output arp_mode, input ready);
    modport sink   (input valid, input arp_mode, output ready);
endinterface

// ===== rtl/core/narp_mod.sv =====
// ----------------------------------------------------------------------------
// narp_mod
// Serial remainder unit: 16-bit dividend by a small count, one bit a cycle.
// ----------------------------------------------------------------------------
module narp_mod #(
    parameter int CNT_W = $clog2(narp_pkg::MAX_NOTES_DEF + 1)
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [narp_pkg::LFSR_W-1:0]     dividend,
    input  logic [CNT_W-1:0]                divisor,
    output logic                            busy,
    output logic [CNT_W-1:0]                rem
);
    import narp_pkg::*;

    logic                   busy_reg, busy_next;
    logic [STEP_CNT_W-1:0]  cnt_reg, cnt_next;
    logic [LFSR_W-1:0]      num_reg, num_next;
    logic [CNT_W-1:0]       div_reg, div_next;
    logic [CNT_W-1:0]       rem_reg, rem_next;
    logic [CNT_W:0]         shifted;
    logic [CNT_W:0]         trial;

    // one restoring step
    always_comb
    begin
        shifted = {rem_reg, num_reg[LFSR_W-1]};
        trial   = shifted - {1'b0, div_reg};
    end

    // sequencing
    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        div_next  = div_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '1;
            num_next  = dividend;
            div_next  = divisor;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            num_next = {num_reg[LFSR_W-2:0], 1'b0};
            if (shifted >= {1'b0, div_reg})
            begin
                rem_next = trial[CNT_W-1:0];
            end
            else
            begin
                rem_next = shifted[CNT_W-1:0];
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        div_reg <= div_next;
        rem_reg <= rem_next;
    end

    assign busy = busy_reg;
    assign rem  = rem_reg;

endmodule

// ===== rtl/core/narp_dp.sv =====
// ----------------------------------------------------------------------------
// narp_dp
// Datapath: sorted pitch table, step position, lfsr, mode and result register.
// ----------------------------------------------------------------------------
module narp_dp #(
    parameter int MAX_NOTES = narp_pkg::MAX_NOTES_DEF,
    parameter int CNT_W     = $clog2(MAX_NOTES + 1)
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  narp_pkg::cmd_t                  cmd,
    output narp_pkg::stat_t                 stat,
    input  logic                            cfg_valid,
    input  logic [narp_pkg::MODE_W-1:0]     cfg_mode,
    input  logic [narp_pkg::KIND_W-1:0]     item_kind,
    input  logic [narp_pkg::PITCH_W-1:0]    item_pitch,
    input  logic                            res_ready,
    output logic                            res_valid,
    output logic [narp_pkg::ACT_W-1:0]      res_action,
    output logic [narp_pkg::PITCH_W-1:0]    res_pitch,
    output logic [CNT_W-1:0]                res_count,
    output logic                            res_running
);
    import narp_pkg::*;

    localparam int POS_W = $clog2(MAX_NOTES);

    logic [PITCH_W-1:0] entry_reg [MAX_NOTES];
    logic [PITCH_W-1:0] entry_next [MAX_NOTES];
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               pos_valid_reg, pos_valid_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [PITCH_W-1:0] cur_reg, cur_next;
    logic               run_reg, run_next;
    logic [LFSR_W-1:0]  lfsr_reg, lfsr_next;
    logic [MODE_W-1:0]  mode_reg;
    logic [KIND_W-1:0]  kind_reg;
    logic [PITCH_W-1:0] pitch_reg;
    logic               out_valid_reg;
    logic [ACT_W-1:0]   out_action_reg;
    logic [PITCH_W-1:0] out_pitch_reg;
    logic [CNT_W-1:0]   out_count_reg;
    logic               out_running_reg;
    logic [PITCH_W-1:0] out_pitch_next;

    logic [MAX_NOTES-1:0] lt;
    logic [MAX_NOTES-1:0] eq;
    logic [LFSR_W-1:0]    dividend;
    logic                 mod_busy;
    logic [CNT_W-1:0]     mod_rem;
    logic [POS_W-1:0]     step_idx;

    // compare every held entry against the request pitch
    always_comb
    begin
        for (int i = 0; i < MAX_NOTES; i++)
        begin
            lt[i] = (CNT_W'(i) < count_reg) && (entry_reg[i] < pitch_reg);
            eq[i] = (CNT_W'(i) < count_reg) && (entry_reg[i] == pitch_reg);
        end
    end

    // status to controller
    always_comb
    begin
        stat.kind      = kind_reg;
        stat.hit       = |eq;
        stat.full      = (count_reg == CNT_W'(MAX_NOTES));
        stat.empty     = (count_reg == '0);
        stat.last_one  = (count_reg == CNT_W'(1));
        stat.running   = run_reg;
        stat.mode_none = (mode_reg == MODE_NONE);
        stat.mod_busy  = mod_busy;
        stat.out_busy  = out_valid_reg && !res_ready;
    end

    // dividend of the next step position
    always_comb
    begin
        case (mode_reg)
            MODE_UP:
            begin
                dividend = pos_valid_reg ? (LFSR_W'(pos_reg) + LFSR_W'(1)) : '0;
            end
            MODE_DOWN:
            begin
                dividend = pos_valid_reg
                    ? (LFSR_W'(pos_reg) + LFSR_W'(count_reg) - LFSR_W'(1))
                    : (LFSR_W'(count_reg) - LFSR_W'(1));
            end
            default:
            begin
                dividend = lfsr_step(lfsr_reg);
            end
        endcase
    end

    narp_mod #(
        .CNT_W (CNT_W)
    ) u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.mod_start),
        .dividend (dividend),
        .divisor  (count_reg),
        .busy     (mod_busy),
        .rem      (mod_rem)
    );

    assign step_idx = mod_rem[POS_W-1:0];

    // state update
    always_comb
    begin
        entry_next     = entry_reg;
        count_next     = count_reg;
        pos_valid_next = pos_valid_reg;
        pos_next       = pos_reg;
        cur_next       = cur_reg;
        run_next       = run_reg;
        lfsr_next      = lfsr_reg;

        if (cmd.mod_start && (mode_reg == MODE_RANDOM))
        begin
            lfsr_next = lfsr_step(lfsr_reg);
        end

        case (cmd.op)
            OP_INSERT:
            begin
                // sorted insert: entries at or above the pitch move up one
                if (!lt[0])
                begin
                    entry_next[0] = pitch_reg;
                end
                for (int i = 1; i < MAX_NOTES; i++)
                begin
                    if (!lt[i])
                    begin
                        entry_next[i] = lt[i-1] ? pitch_reg : entry_reg[i-1];
                    end
                end
                count_next = count_reg + 1'b1;
                run_next   = 1'b1;
            end
            OP_REMOVE:
            begin
                // entries from the match upward move down one
                for (int i = 0; i < MAX_NOTES - 1; i++)
                begin
                    if (!lt[i])
                    begin
                        entry_next[i] = entry_reg[i+1];
                    end
                end
                count_next = count_reg - 1'b1;
                if (stat.last_one && run_reg)
                begin
                    run_next       = 1'b0;
                    pos_valid_next = 1'b0;
                    pos_next       = '0;
                end
            end
            OP_CLEAR:
            begin
                count_next     = '0;
                run_next       = 1'b0;
                pos_valid_next = 1'b0;
                pos_next       = '0;
            end
            OP_STEP:
            begin
                pos_next       = step_idx;
                pos_valid_next = 1'b1;
                cur_next       = entry_reg[step_idx];
            end
            default:
            begin
            end
        endcase
    end

    // pitch reported with the action
    always_comb
    begin
        case (cmd.action)
            ACT_START: out_pitch_next = cur_next;
            ACT_STOP:  out_pitch_next = cur_reg;
            default:   out_pitch_next = '0;
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            pos_valid_reg <= 1'b0;
            pos_reg       <= '0;
            cur_reg       <= '0;
            run_reg       <= 1'b0;
            lfsr_reg      <= LFSR_SEED;
            mode_reg      <= MODE_NONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            pos_valid_reg <= pos_valid_next;
            pos_reg       <= pos_next;
            cur_reg       <= cur_next;
            run_reg       <= run_next;
            lfsr_reg      <= lfsr_next;
            if (cfg_valid)
            begin
                mode_reg <= cfg_mode;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
        if (cmd.item_load)
        begin
            kind_reg  <= item_kind;
            pitch_reg <= item_pitch;
        end
        if (cmd.out_load)
        begin
            out_action_reg  <= cmd.action;
            out_pitch_reg   <= out_pitch_next;
            out_count_reg   <= count_next;
            out_running_reg <= run_next;
        end
    end

    assign res_valid   = out_valid_reg;
    assign res_action  = out_action_reg;
    assign res_pitch   = out_pitch_reg;
    assign res_count   = out_count_reg;
    assign res_running = out_running_reg;

endmodule

// ===== rtl/core/narp_ctrl.sv =====
// ----------------------------------------------------------------------------
// narp_ctrl
// Controller: sequences each request and picks its operation and action.
// ----------------------------------------------------------------------------
module narp_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_ready,
    input  narp_pkg::stat_t     stat,
    output narp_pkg::cmd_t      cmd
);
    import narp_pkg::*;

    state_t state_reg, state_next;
    logic   step_go;

    assign step_go = (stat.kind == KIND_STEP_BEGIN) && stat.running
                     && !stat.mode_none && !stat.empty;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (step_go)
                begin
                    state_next = ST_MOD;
                end
                else if (!stat.out_busy)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_MOD:
            begin
                if (!stat.mod_busy && !stat.out_busy)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        cmd        = '0;
        cmd.op     = OP_NONE;
        cmd.action = ACT_NONE;
        item_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                item_ready    = 1'b1;
                cmd.item_load = item_valid;
            end
            ST_EXEC:
            begin
                if (step_go)
                begin
                    cmd.mod_start = 1'b1;
                end
                else if (!stat.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    case (stat.kind)
                        KIND_NOTE_ON:
                        begin
                            if (stat.hit)
                            begin
                                cmd.action = ACT_NONE;
                            end
                            else if (stat.full)
                            begin
                                cmd.action = ACT_DROPPED;
                            end
                            else
                            begin
                                cmd.op     = OP_INSERT;
                                cmd.action = stat.running ? ACT_NONE : ACT_RUN_START;
                            end
                        end
                        KIND_NOTE_OFF:
                        begin
                            if (stat.hit)
                            begin
                                cmd.op     = OP_REMOVE;
                                cmd.action = (stat.last_one && stat.running)
                                             ? ACT_RUN_STOP : ACT_NONE;
                            end
                        end
                        KIND_ALL_OFF:
                        begin
                            if (!stat.empty)
                            begin
                                cmd.op     = OP_CLEAR;
                                cmd.action = ACT_RUN_STOP;
                            end
                        end
                        KIND_STEP_END:
                        begin
                            cmd.action = stat.running ? ACT_STOP : ACT_NONE;
                        end
                        default:
                        begin
                            cmd.action = ACT_NONE;
                        end
                    endcase
                end
            end
            ST_MOD:
            begin
                if (!stat.mod_busy && !stat.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    cmd.op       = OP_STEP;
                    cmd.action   = ACT_START;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/core/note_arpeggiator_unit.sv =====
// ----------------------------------------------------------------------------
// note_arpeggiator_unit
// Arpeggiator over an ascending table of held note pitches.
// ----------------------------------------------------------------------------
// Takes note on, note off, all notes off, step begin and step end requests and
// returns one result per request. A step begin that starts a note waits on the
// serial remainder unit, which reduces the next position modulo the held count
// one dividend bit per cycle over 16 bits. A finished result sits in an output
// register, so a new request is accepted while the previous result still waits.
// The mode register may be written at any time the block is idle; mode none
// makes step begin requests no-ops.
module note_arpeggiator_unit #(
    parameter int MAX_NOTES = narp_pkg::MAX_NOTES_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    narp_item_if.sink       item,
    narp_result_if.source   result,
    narp_cfg_if.sink        cfg
);
    import narp_pkg::*;

    localparam int CNT_W = $clog2(MAX_NOTES + 1);

    cmd_t  cmd;
    stat_t stat;
    logic  item_ready;

    assign item.ready = item_ready;
    assign cfg.ready  = 1'b1;

    narp_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item.valid),
        .item_ready (item_ready),
        .stat       (stat),
        .cmd        (cmd)
    );

    narp_dp #(
        .MAX_NOTES (MAX_NOTES),
        .CNT_W     (CNT_W)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .cfg_valid   (cfg.valid),
        .cfg_mode    (cfg.arp_mode),
        .item_kind   (item.kind),
        .item_pitch  (item.pitch_code),
        .res_ready   (result.ready),
        .res_valid   (result.valid),
        .res_action  (result.action),
        .res_pitch   (result.note_pitch),
        .res_count   (result.held_count),
        .res_running (result.running)
    );

    // held count never exceeds the table depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (result.held_count <= CNT_W'(MAX_NOTES)))
        else $error("held count beyond table depth");

    // an active run always has notes held
    a_run_has_notes: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.running) |-> (result.held_count != '0))
        else $error("run active with empty table");

    // a started note only comes from an active run
    a_start_running: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && (result.action == ACT_START)) |-> result.running)
        else $error("note started outside a run");

    // no request is taken while the remainder unit works
    a_busy_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
        stat.mod_busy |-> !item.ready)
        else $error("request accepted during step computation");

endmodule

// ===== dv/note_arpeggiator_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// note_arpeggiator_unit_tb
// Self-checking bench for the note arpeggiator. A queue-fed driver sends note
// and tick requests with random gaps, and the result side stalls at random.
// A local model of the pitch table, step position and lfsr predicts every
// result, which a monitor compares field by field. The arpeggio mode changes
// between phases while the block is idle.
// ----------------------------------------------------------------------------
module note_arpeggiator_unit_tb;
    import narp_pkg::*;

    localparam int NOTES       = MAX_NOTES_DEF;
    localparam int CNT_W       = $clog2(NOTES + 1);
    localparam int MAX_WAIT    = 12;
    localparam int DRAIN_CYC   = 40;
    localparam int QUIET_LIMIT = 2000;
    localparam int PHASE_REQS  = 235;
    localparam int POOL_MAX    = 24;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [PITCH_W-1:0] pitch;
    } note_req_t;

    typedef struct packed {
        logic [ACT_W-1:0]   action;
        logic [PITCH_W-1:0] note_pitch;
        logic [CNT_W-1:0]   held_count;
        logic               running;
    } arp_result_t;

    logic clk;
    logic rst_n;

    narp_item_if                        item ();
    narp_result_if #(.MAX_NOTES(NOTES)) result ();
    narp_cfg_if                         cfg ();

    note_arpeggiator_unit #(
        .MAX_NOTES(NOTES)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .result (result),
        .cfg    (cfg)
    );

    // model of the arpeggiator state
    logic [PITCH_W-1:0] held_tab [NOTES];
    int                 held_n;
    logic               pos_ok;
    int                 pos;
    logic [PITCH_W-1:0] cur_pitch;
    logic               run_on;
    logic [LFSR_W-1:0]  lfsr;
    logic [MODE_W-1:0]  arp_mode_q;

    // request and result bookkeeping
    note_req_t   note_reqs [$];
    arp_result_t due_results [$];
    int          reqs_queued;
    int          reqs_taken;
    int          reqs_seen;
    int          results_taken;
    int          results_seen;
    int          cfg_taken;
    int          errors;

    // idling state of both sides
    int req_gap;
    int req_calm;
    int res_hold;
    int res_calm;

    // pitch pool of the current phase
    logic [PITCH_W-1:0] pitch_pool [POOL_MAX];
    int                 pool_n;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // expected result of one request, advancing the model state
    task automatic arp_next_result(input logic [KIND_W-1:0] kind,
                                   input logic [PITCH_W-1:0] pitch,
                                   output arp_result_t r);
        int at;
        int k;
        int p;
        r.action     = ACT_NONE;
        r.note_pitch = '0;
        case (kind)
            KIND_NOTE_ON:
            begin
                at = 0;
                while (at < held_n && held_tab[at] < pitch)
                    at++;
                // a duplicate leaves the table as it is
                if (!(at < held_n && held_tab[at] == pitch))
                begin
                    if (held_n >= NOTES)
                        r.action = ACT_DROPPED;
                    else
                    begin
                        for (k = held_n; k > at; k--)
                            held_tab[k] = held_tab[k-1];
                        held_tab[at] = pitch;
                        held_n++;
                        if (!run_on)
                        begin
                            run_on   = 1'b1;
                            r.action = ACT_RUN_START;
                        end
                    end
                end
            end
            KIND_NOTE_OFF:
            begin
                at = 0;
                while (at < held_n && held_tab[at] != pitch)
                    at++;
                if (at < held_n)
                begin
                    for (k = at; k + 1 < held_n; k++)
                        held_tab[k] = held_tab[k+1];
                    held_n--;
                    if (held_n == 0 && run_on)
                    begin
                        run_on   = 1'b0;
                        pos_ok   = 1'b0;
                        pos      = 0;
                        r.action = ACT_RUN_STOP;
                    end
                end
            end
            KIND_ALL_OFF:
            begin
                if (held_n != 0)
                begin
                    held_n   = 0;
                    run_on   = 1'b0;
                    pos_ok   = 1'b0;
                    pos      = 0;
                    r.action = ACT_RUN_STOP;
                end
            end
            KIND_STEP_BEGIN:
            begin
                if (run_on && arp_mode_q != MODE_NONE && held_n != 0)
                begin
                    case (arp_mode_q)
                        MODE_UP:   p = pos_ok ? (pos + 1) % held_n : 0;
                        MODE_DOWN: p = pos_ok ? (pos + held_n - 1) % held_n : held_n - 1;
                        default:
                        begin
                            lfsr = {lfsr[0] ^ lfsr[2] ^ lfsr[3] ^ lfsr[5], lfsr[LFSR_W-1:1]};
                            p    = int'(lfsr) % held_n;
                        end
                    endcase
                    pos          = p;
                    pos_ok       = 1'b1;
                    cur_pitch    = held_tab[p];
                    r.action     = ACT_START;
                    r.note_pitch = cur_pitch;
                end
            end
            KIND_STEP_END:
            begin
                if (run_on)
                begin
                    r.action     = ACT_STOP;
                    r.note_pitch = cur_pitch;
                end
            end
            default: ;
        endcase
        r.held_count = CNT_W'(held_n);
        r.running    = run_on;
    endtask

    // gap or stall length, with occasional stretches of none
    function automatic int draw_gap(inout int calm);
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 29) == 0)
        begin
            calm = $urandom_range(20, 60);
            return 0;
        end
        return $urandom_range(0, MAX_WAIT);
    endfunction

    function automatic logic [PITCH_W-1:0] pick_pitch();
        if ($urandom_range(0, 99) < 85)
            return pitch_pool[$urandom_range(0, pool_n - 1)];
        return PITCH_W'($urandom);
    endfunction

    task automatic add_req(input logic [KIND_W-1:0] kind, input logic [PITCH_W-1:0] pitch);
        note_reqs.push_back('{kind: kind, pitch: pitch});
        reqs_queued++;
    endtask

    // wait until every request is answered, then let the block drain
    task automatic wait_idle();
        while (note_reqs.size() != 0 || reqs_taken != reqs_queued || due_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYC) @(negedge clk);
    endtask

    task automatic write_mode(input logic [MODE_W-1:0] m);
        int seen;
        wait_idle();
        seen = cfg_taken;
        cfg.arp_mode <= m;
        cfg.valid    <= 1'b1;
        while (cfg_taken == seen)
            @(negedge clk);
        cfg.valid <= 1'b0;
    endtask

    // random phase: mostly note and tick traffic over a small pitch pool
    task automatic run_phase(input logic [MODE_W-1:0] m);
        int done;
        int roll;
        write_mode(m);
        pool_n        = $urandom_range(4, POOL_MAX);
        pitch_pool[0] = '0;
        pitch_pool[1] = '1;
        for (int k = 2; k < POOL_MAX; k++)
            pitch_pool[k] = PITCH_W'($urandom);
        done = 0;
        while (done < PHASE_REQS)
        begin
            roll = $urandom_range(0, 99);
            done++;
            if (roll < 32)
                add_req(KIND_NOTE_ON, pick_pitch());
            else if (roll < 58)
                add_req(KIND_NOTE_OFF, pick_pitch());
            else if (roll < 82)
                add_req(KIND_STEP_BEGIN, PITCH_W'($urandom));
            else if (roll < 94)
                add_req(KIND_STEP_END, PITCH_W'($urandom));
            else if (roll < 97)
                add_req(KIND_ALL_OFF, PITCH_W'($urandom));
            else
            begin
                // unused kinds, ignored by the block
                add_req(KIND_STEP_END + KIND_W'($urandom_range(1, 3)), PITCH_W'($urandom));
                done--;
            end
        end
    endtask

    // request driver
    always @(negedge clk)
    begin : req_driver
        note_req_t nr;
        logic      v;
        if (rst_n)
        begin
            v = item.valid;
            if (item.valid && reqs_taken != reqs_seen)
            begin
                reqs_seen = reqs_taken;
                v         = 1'b0;
                req_gap   = draw_gap(req_calm);
            end
            if (!v)
            begin
                if (req_gap > 0)
                    req_gap--;
                else if (note_reqs.size() != 0)
                begin
                    nr = note_reqs.pop_front();
                    v  = 1'b1;
                    item.kind       <= nr.kind;
                    item.pitch_code <= nr.pitch;
                end
            end
            item.valid <= v;
        end
    end

    // accepted request: predict its result
    always @(posedge clk)
    begin : req_capture
        arp_result_t r;
        if (rst_n && item.valid && item.ready)
        begin
            arp_next_result(item.kind, item.pitch_code, r);
            due_results.push_back(r);
            reqs_taken++;
        end
    end

    // mode write taken by the block
    always @(posedge clk)
    begin : cfg_capture
        if (rst_n && cfg.valid && cfg.ready)
        begin
            arp_mode_q = cfg.arp_mode;
            cfg_taken++;
        end
    end

    // result ready with random stalls
    always @(negedge clk)
    begin : result_sink
        if (rst_n)
        begin
            if (results_taken != results_seen)
            begin
                results_seen = results_taken;
                res_hold     = draw_gap(res_calm);
            end
            if (res_hold > 0)
            begin
                res_hold--;
                result.ready <= 1'b0;
            end
            else
                result.ready <= 1'b1;
        end
    end

    // result monitor
    always @(posedge clk)
    begin : result_check
        arp_result_t want;
        if (rst_n && result.valid && result.ready)
        begin
            results_taken++;
            if (due_results.size() == 0)
            begin
                errors++;
                $display("%0t: result with no request pending: action %0d pitch %h",
                         $time, result.action, result.note_pitch);
            end
            else
            begin
                want = due_results.pop_front();
                if (result.action !== want.action)
                begin
                    errors++;
                    $display("%0t: action expected %0d actual %0d",
                             $time, want.action, result.action);
                end
                if (result.note_pitch !== want.note_pitch)
                begin
                    errors++;
                    $display("%0t: note_pitch expected %h actual %h",
                             $time, want.note_pitch, result.note_pitch);
                end
                if (result.held_count !== want.held_count)
                begin
                    errors++;
                    $display("%0t: held_count expected %0d actual %0d",
                             $time, want.held_count, result.held_count);
                end
                if (result.running !== want.running)
                begin
                    errors++;
                    $display("%0t: running expected %0d actual %0d",
                             $time, want.running, result.running);
                end
            end
        end
    end

    // watchdog on cycles without any handshake
    initial
    begin : watchdog
        int quiet;
        int last_sum;
        int now_sum;
        quiet    = 0;
        last_sum = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(negedge clk);
            now_sum = reqs_taken + results_taken + cfg_taken;
            if (now_sum != last_sum || !rst_n)
            begin
                quiet    = 0;
                last_sum = now_sum;
            end
            else
                quiet++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    // main sequence
    initial
    begin : main_seq
        rst_n           = 1'b0;
        item.valid      = 1'b0;
        item.kind       = KIND_NOTE_ON;
        item.pitch_code = '0;
        result.ready    = 1'b0;
        cfg.valid       = 1'b0;
        cfg.arp_mode    = MODE_NONE;

        for (int k = 0; k < NOTES; k++)
            held_tab[k] = '0;
        held_n     = 0;
        pos_ok     = 1'b0;
        pos        = 0;
        cur_pitch  = '0;
        run_on     = 1'b0;
        lfsr       = LFSR_SEED;
        arp_mode_q = MODE_NONE;

        reqs_queued   = 0;
        reqs_taken    = 0;
        reqs_seen     = 0;
        results_taken = 0;
        results_seen  = 0;
        cfg_taken     = 0;
        errors        = 0;
        req_gap       = 0;
        req_calm      = 0;
        res_hold      = 0;
        res_calm      = 0;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // mode none from reset: empty table, extremes, duplicate, unknown off
        add_req(KIND_STEP_BEGIN, 16'h0000);
        add_req(KIND_ALL_OFF, 16'hFFFF);
        add_req(KIND_NOTE_ON, 16'h0000);
        add_req(KIND_NOTE_ON, 16'hFFFF);
        add_req(KIND_NOTE_ON, 16'hFFFF);
        add_req(KIND_STEP_BEGIN, 16'h0000);
        add_req(KIND_STEP_END, 16'h0000);
        add_req(KIND_NOTE_OFF, 16'h1234);
        add_req(KIND_NOTE_OFF, 16'hFFFF);
        add_req(KIND_NOTE_OFF, 16'h0000);
        add_req(KIND_STEP_END, 16'hFFFF);

        // up mode: ordered insert, wrap, and a position past the count
        write_mode(MODE_UP);
        add_req(KIND_NOTE_ON, 16'h0005);
        add_req(KIND_NOTE_ON, 16'h0009);
        add_req(KIND_NOTE_ON, 16'h0007);
        add_req(KIND_STEP_BEGIN, 16'h0000);
        add_req(KIND_STEP_BEGIN, 16'h0000);
        add_req(KIND_STEP_BEGIN, 16'h0000);
        add_req(KIND_STEP_END, 16'h0000);
        add_req(KIND_NOTE_OFF, 16'h0005);
        add_req(KIND_STEP_BEGIN, 16'h0000);

        // down mode: first step from the top after the run restarts
        write_mode(MODE_DOWN);
        add_req(KIND_STEP_BEGIN, 16'h0000);
        add_req(KIND_ALL_OFF, 16'h0000);
        add_req(KIND_NOTE_ON, 16'h8000);
        add_req(KIND_STEP_BEGIN, 16'h0000);

        // random mode
        write_mode(MODE_RANDOM);
        add_req(KIND_NOTE_ON, 16'h0001);
        add_req(KIND_STEP_BEGIN, 16'h0000);
        add_req(KIND_STEP_END, 16'h0000);

        run_phase(MODE_UP);
        run_phase(MODE_DOWN);
        run_phase(MODE_RANDOM);
        run_phase(MODE_NONE);
        run_phase(MODE_RANDOM);
        run_phase(MODE_DOWN);
        run_phase(MODE_UP);
        run_phase(MODE_RANDOM);

        wait_idle();
        if (errors == 0 && due_results.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/narp_pkg.sv
rtl/core/narp_item_if.sv
rtl/core/narp_result_if.sv
rtl/core/narp_cfg_if.sv
rtl/core/narp_mod.sv
rtl/core/narp_dp.sv
rtl/core/narp_ctrl.sv
rtl/core/note_arpeggiator_unit.sv
dv/note_arpeggiator_unit_tb.sv
